### rtl/sop_pkg.sv
// Package for the stereo panned oscillator: codes, the microcode program,
// the LFSR step and the quarter-wave sine polynomial used to build the table.
// No dependencies; every other file of the block but sop_in_if uses it.
`default_nettype none

package sop_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_WIDTH_DEF     = 16;

  localparam int CfgIndexW = 4;
  localparam int CfgDataW  = 24;

  localparam logic [CfgIndexW-1:0] REG_WAVEFORM  = 4'd0;
  localparam logic [CfgIndexW-1:0] REG_FREQUENCY = 4'd1;
  localparam logic [CfgIndexW-1:0] REG_AMPLITUDE = 4'd2;
  localparam logic [CfgIndexW-1:0] REG_PAN       = 4'd3;

  localparam logic [15:0] AmplitudeReset = 16'd256;
  localparam logic [31:0] LfsrMask       = 32'h8020_0003;
  localparam logic [31:0] LfsrSeed       = 32'hACE1_ACE1;

  localparam logic [63:0] PolyC [6] = '{
    64'd1686629713, 64'd693598668, 64'd85569306,
    64'd5026996,    64'd172272,    64'd3864
  };

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SAW    = 2'd1,
    WAVE_SQUARE = 2'd2,
    WAVE_NOISE  = 2'd3
  } wave_t;

  typedef enum logic [2:0] {
    A_ZERO, A_FREQ, A_PHASE, A_LGAIN, A_RGAIN, A_WAVEL, A_WAVER
  } a_sel_t;

  typedef enum logic [2:0] {
    B_ZERO, B_TIME, B_QUARTER, B_AMP, B_GAINAMP_L, B_GAINAMP_R
  } b_sel_t;

  typedef enum logic [2:0] {
    D_NONE, D_PHASE, D_INDEX, D_GAINAMP_L, D_GAINAMP_R, D_PROD_L, D_PROD_R
  } dest_t;

  typedef enum logic [1:0] {
    C_NEXT, C_NO_INPUT, C_OUT_BUSY
  } cond_t;

  typedef logic [2:0] step_t;

  typedef struct packed {
    a_sel_t a_sel;
    b_sel_t b_sel;
    dest_t  dest;
    logic   wave_en;
    logic   wave_right;
    logic   round_left;
    logic   load_out;
    logic   take_in;
    cond_t  cond;
    step_t  target;
  } ctrl_t;

  // One control word per step. A true condition jumps to the target,
  // otherwise the step counter advances and wraps from the last step.
  function automatic ctrl_t program_word(input step_t s);
    ctrl_t w;
    w = '0;
    case (s)
      3'd0: begin
        w.take_in = 1'b1;
        w.cond    = C_NO_INPUT;
        w.target  = 3'd0;
      end
      3'd1: begin
        w.a_sel = A_FREQ;
        w.b_sel = B_TIME;
        w.dest  = D_PHASE;
      end
      3'd2: begin
        w.a_sel = A_PHASE;
        w.b_sel = B_QUARTER;
        w.dest  = D_INDEX;
      end
      3'd3: begin
        w.a_sel = A_LGAIN;
        w.b_sel = B_AMP;
        w.dest  = D_GAINAMP_L;
      end
      3'd4: begin
        w.a_sel   = A_RGAIN;
        w.b_sel   = B_AMP;
        w.dest    = D_GAINAMP_R;
        w.wave_en = 1'b1;
      end
      3'd5: begin
        w.a_sel      = A_WAVEL;
        w.b_sel      = B_GAINAMP_L;
        w.dest       = D_PROD_L;
        w.wave_en    = 1'b1;
        w.wave_right = 1'b1;
      end
      3'd6: begin
        w.a_sel      = A_WAVER;
        w.b_sel      = B_GAINAMP_R;
        w.dest       = D_PROD_R;
        w.round_left = 1'b1;
      end
      3'd7: begin
        w.load_out = 1'b1;
        w.cond     = C_OUT_BUSY;
        w.target   = 3'd7;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] lfsr_next(input logic [31:0] s);
    logic [31:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LfsrMask;
    end
    return n;
  endfunction

  // Odd polynomial for sin(pi/2 * u), u in Q30, rounded to Q15.
  function automatic logic [15:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] r;
    logic [63:0] q;
    u2 = (u * u) >> 30;
    r  = PolyC[5];
    for (int n = 4; n >= 0; n--) begin
      r = PolyC[n] - ((r * u2) >> 30);
    end
    r = (r * u) >> 30;
    q = (r * 64'd32768 + (64'd1 << 29)) >> 30;
    return q[15:0];
  endfunction

endpackage

`default_nettype wire

### rtl/sop_in_if.sv
// Input channel of the stereo panned oscillator: one sample time per transaction.
// Depends on nothing but the handshake convention valid and ready.
`default_nettype none

interface sop_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;

  modport source (output valid, output sample_time, input ready);
  modport sink (input valid, input sample_time, output ready);
endinterface

`default_nettype wire

### rtl/sop_out_if.sv
// Output channel of the stereo panned oscillator: one stereo pair per transaction.
// Takes its default sample width from sop_pkg.
`default_nettype none

interface sop_out_if #(
  parameter int SAMPLE_WIDTH = sop_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_sample;
  logic signed [SAMPLE_WIDTH-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

### rtl/sop_sine_rom.sv
// Quarter-wave sine table with a registered read port.
// Contents are computed at elaboration with sop_pkg::quarter_sine.
`default_nettype none

module sop_sine_rom #(
  parameter int SINE_TABLE_DEPTH = sop_pkg::SINE_TABLE_DEPTH_DEF,
  localparam int Quarter = SINE_TABLE_DEPTH / 4,
  localparam int AddrW = $clog2(Quarter + 1)
) (
  input  wire logic             clk,
  input  wire logic [AddrW-1:0] addr,
  output logic      [15:0]      data
);

  logic [15:0] sine_tab [Quarter + 1];

  for (genvar k = 0; k <= Quarter; k++) begin : g_entry
    localparam logic [63:0] U = (64'(k) << 30) / Quarter;
    localparam logic [15:0] V = sop_pkg::quarter_sine(U);
    assign sine_tab[k] = V;
  end

  always_ff @(posedge clk) begin
    data <= sine_tab[addr];
  end

endmodule

`default_nettype wire

### rtl/stereo_panned_oscillator_core.sv
// Stereo panned oscillator top level: microcoded sequencer, shared multiplier,
// waveform unit and output register. Uses sop_pkg, sop_in_if, sop_out_if, sop_sine_rom.
//
// Usage: each transaction on times carries one sample time (U16.16 seconds).
// For each one, samples delivers one transaction with a left and a right sample
// in signed Q(SAMPLE_WIDTH-1), rounded and saturated. The configuration port writes
// waveform, frequency, amplitude and pan by index; the user must write only while
// the block is idle, which the block does not enforce. Unknown indexes are ignored.
// An eight-step program runs all products through one multiplier, so a new
// item is accepted only after the program is through with the last one. The
// input is ready only in the first program step. Results are held in an
// output register, so the next item is accepted and worked on while a result
// waits; if the receiver still holds the previous result when the next one is
// done, the last step waits.
// Reset clears the configuration to waveform sine, frequency zero, unity
// amplitude and center pan, seeds the noise LFSR and empties the output.
`default_nettype none

module stereo_panned_oscillator_core #(
  parameter int SINE_TABLE_DEPTH = sop_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_WIDTH     = sop_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write_en,
  input  wire logic [sop_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [sop_pkg::CfgDataW-1:0]  cfg_data,
  sop_in_if.sink                              times,
  sop_out_if.source                           samples
);

  localparam int Quarter = SINE_TABLE_DEPTH / 4;
  localparam int IndexW  = $clog2(Quarter);
  localparam int AddrW   = $clog2(Quarter + 1);
  localparam int Sh      = 39 - SAMPLE_WIDTH;
  localparam logic signed [49:0] Half = 50'sd1 <<< (Sh - 1);
  localparam logic signed [49:0] MaxV = (50'sd1 <<< (SAMPLE_WIDTH - 1)) - 50'sd1;
  localparam logic signed [49:0] MinV = -(50'sd1 <<< (SAMPLE_WIDTH - 1));

  sop_pkg::wave_t     waveform;
  logic        [23:0] frequency;
  logic        [15:0] amplitude;
  logic signed [15:0] pan;
  logic        [31:0] lfsr;
  logic        [31:0] lfsr_stepped;

  sop_pkg::step_t step;
  sop_pkg::step_t step_next;
  sop_pkg::ctrl_t ctrl;
  logic           cond_true;
  logic           accept;
  logic           out_valid;
  logic           out_busy;
  logic           load;

  logic        [23:0] t_reg;
  logic        [23:0] phase;
  logic [IndexW-1:0]  index;
  logic        [31:0] gainamp_l;
  logic        [31:0] gainamp_r;
  logic signed [48:0] prod_l;
  logic signed [48:0] prod_r;
  logic signed [16:0] w_l;
  logic signed [16:0] w_r;
  logic signed [16:0] w_calc;
  logic signed [16:0] sine_val;
  logic        [15:0] lgain;
  logic        [15:0] rgain;

  logic signed [24:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [58:0] mul_p;

  logic  [AddrW-1:0] rom_addr;
  logic       [15:0] rom_q;

  logic signed [48:0] rnd_in;
  logic signed [49:0] rnd_sum;
  logic signed [49:0] rnd_shift;
  logic [SAMPLE_WIDTH-1:0] rnd_res;
  logic [SAMPLE_WIDTH-1:0] res_l;
  logic signed [SAMPLE_WIDTH-1:0] left_q;
  logic signed [SAMPLE_WIDTH-1:0] right_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform  <= sop_pkg::WAVE_SINE;
      frequency <= '0;
      amplitude <= sop_pkg::AmplitudeReset;
      pan       <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        sop_pkg::REG_WAVEFORM:  waveform  <= sop_pkg::wave_t'(cfg_data[1:0]);
        sop_pkg::REG_FREQUENCY: frequency <= cfg_data[23:0];
        sop_pkg::REG_AMPLITUDE: amplitude <= cfg_data[15:0];
        sop_pkg::REG_PAN:       pan       <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  // Sequencer.
  assign ctrl     = sop_pkg::program_word(step);
  assign out_busy = out_valid && !samples.ready;
  assign accept   = times.valid && ctrl.take_in;
  assign load     = ctrl.load_out && !out_busy;

  always_comb begin
    case (ctrl.cond)
      sop_pkg::C_NO_INPUT: cond_true = !times.valid;
      sop_pkg::C_OUT_BUSY: cond_true = out_busy;
      default:             cond_true = 1'b0;
    endcase
    step_next = cond_true ? ctrl.target : step + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

  assign times.ready = ctrl.take_in;

  // Channel gains in Q15.
  assign lgain = pan[15] ? 16'h8000 : 16'h8000 - 16'(pan);
  assign rgain = pan[15] ? 16'h8000 + 16'(pan) : 16'h8000;

  // Shared multiplier.
  always_comb begin
    case (ctrl.a_sel)
      sop_pkg::A_FREQ:  mul_a = $signed({1'b0, frequency});
      sop_pkg::A_PHASE: mul_a = $signed({3'b0, phase[21:0]});
      sop_pkg::A_LGAIN: mul_a = $signed({9'b0, lgain});
      sop_pkg::A_RGAIN: mul_a = $signed({9'b0, rgain});
      sop_pkg::A_WAVEL: mul_a = 25'(w_l);
      sop_pkg::A_WAVER: mul_a = 25'(w_r);
      default:          mul_a = '0;
    endcase
    case (ctrl.b_sel)
      sop_pkg::B_TIME:      mul_b = $signed({10'b0, t_reg});
      sop_pkg::B_QUARTER:   mul_b = 34'(Quarter);
      sop_pkg::B_AMP:       mul_b = $signed({18'b0, amplitude});
      sop_pkg::B_GAINAMP_L: mul_b = $signed({2'b0, gainamp_l});
      sop_pkg::B_GAINAMP_R: mul_b = $signed({2'b0, gainamp_r});
      default:              mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (accept) begin
      t_reg <= times.sample_time[23:0];
    end
    case (ctrl.dest)
      sop_pkg::D_PHASE:     phase     <= mul_p[23:0];
      sop_pkg::D_INDEX:     index     <= mul_p[22 +: IndexW];
      sop_pkg::D_GAINAMP_L: gainamp_l <= mul_p[31:0];
      sop_pkg::D_GAINAMP_R: gainamp_r <= mul_p[31:0];
      sop_pkg::D_PROD_L:    prod_l    <= mul_p[48:0];
      sop_pkg::D_PROD_R:    prod_r    <= mul_p[48:0];
      default: ;
    endcase
  end

  // Sine table, mirrored in odd quadrants.
  assign rom_addr = phase[22] ? AddrW'(Quarter) - AddrW'(index) : AddrW'(index);

  sop_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  // Waveform unit.
  assign lfsr_stepped = sop_pkg::lfsr_next(lfsr);
  assign sine_val     = $signed({1'b0, rom_q});

  always_comb begin
    case (waveform)
      sop_pkg::WAVE_SINE:   w_calc = phase[23] ? -sine_val : sine_val;
      sop_pkg::WAVE_SAW:    w_calc = 17'sd32768 - $signed({1'b0, phase[23:8]});
      sop_pkg::WAVE_SQUARE: w_calc = phase[23] ? 17'sd32768 : -17'sd32768;
      default:              w_calc = $signed({1'b0, lfsr_stepped[31:16]}) - 17'sd32768;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr <= sop_pkg::LfsrSeed;
    end else if (ctrl.wave_en && waveform == sop_pkg::WAVE_NOISE) begin
      lfsr <= lfsr_stepped;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wave_en) begin
      if (ctrl.wave_right) begin
        w_r <= (waveform == sop_pkg::WAVE_NOISE) ? w_calc : w_l;
      end else begin
        w_l <= w_calc;
      end
    end
  end

  // Rounding to nearest with ties away from zero, then saturation.
  assign rnd_in  = ctrl.round_left ? prod_l : prod_r;
  assign rnd_sum = 50'(rnd_in) + Half - 50'(rnd_in[48]);
  assign rnd_shift = rnd_sum >>> Sh;

  always_comb begin
    if (rnd_shift > MaxV) begin
      rnd_res = MaxV[SAMPLE_WIDTH-1:0];
    end else if (rnd_shift < MinV) begin
      rnd_res = MinV[SAMPLE_WIDTH-1:0];
    end else begin
      rnd_res = rnd_shift[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.round_left) begin
      res_l <= rnd_res;
    end
    if (load) begin
      left_q  <= $signed(res_l);
      right_q <= $signed(rnd_res);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (samples.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign samples.valid        = out_valid;
  assign samples.left_sample  = left_q;
  assign samples.right_sample = right_q;

endmodule

`default_nettype wire

### rtl/sop_checker.sv
// Port-level checker for the stereo panned oscillator and its bind statement.
// Depends on stereo_panned_oscillator_core and the channel interfaces.
`default_nettype none

module sop_checker #(
  parameter int SAMPLE_WIDTH = sop_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] left_sample,
  input wire logic [SAMPLE_WIDTH-1:0] right_sample
);

  // After reset the block is empty and waits for an input transaction.
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // A held result keeps its values until the receiver takes it.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_sample) && $stable(right_sample))
    else $error("stalled result changed");

  // The block works on one item at a time, so it does not take another input right after one.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input accepted again too early");

  // A result never appears in the cycle right after an input transaction.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind stereo_panned_oscillator_core sop_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sop_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (times.valid),
  .in_ready     (times.ready),
  .out_valid    (samples.valid),
  .out_ready    (samples.ready),
  .left_sample  (samples.left_sample),
  .right_sample (samples.right_sample)
);

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stereo_panned_oscillator_core: directed, random and
// backpressure tests against an in-bench predictor of the oscillator and panner.
// Depends on sop_pkg, sop_in_if, sop_out_if and the core itself.

module tb;
  import sop_pkg::*;

  localparam int SampleW      = SAMPLE_WIDTH_DEF;
  localparam int QuarterDepth = SINE_TABLE_DEPTH_DEF / 4;
  localparam int RoundShift   = 39 - SampleW;
  localparam longint SampleMax = (64'sd1 <<< (SampleW - 1)) - 1;
  localparam int CycleLimit   = 1000000;
  localparam int LongHold     = 300;
  localparam int SettleCycles = 20;
  localparam int PhaseCount   = 20;
  localparam int PhaseItems   = 100;

  localparam logic [15:0] UnityGain = 16'd256;
  localparam logic [31:0] NoiseTaps = 32'h8020_0003;
  localparam logic [31:0] NoiseSeed = 32'hACE1_ACE1;
  localparam logic [CfgIndexW-1:0] RegUnmapped = REG_PAN + CfgIndexW'(1);
  localparam wave_t AllWaves [4] = '{WAVE_SINE, WAVE_SAW, WAVE_SQUARE, WAVE_NOISE};

  localparam bit [63:0] SineCoef [6] = '{
    64'd1686629713, 64'd693598668, 64'd85569306,
    64'd5026996,    64'd172272,    64'd3864
  };

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } stereo_pair_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_write_en;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  sop_in_if times ();
  sop_out_if #(.SAMPLE_WIDTH(SampleW)) samples ();

  stereo_panned_oscillator_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .times        (times),
    .samples      (samples)
  );

  wave_t              waveform_q;
  logic [23:0]        frequency_q;
  logic [15:0]        amplitude_q;
  logic signed [15:0] pan_q;
  logic [31:0]        noise_q;
  int                 sine_quarter [0:QuarterDepth];

  stereo_pair_t expected_pairs [$];
  stereo_pair_t oldest;
  int fail_count = 0;
  int cycle_count = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;
  bit hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int wave_value(input logic [23:0] ph);
    int idx;
    int v;
    logic lsb;
    case (waveform_q)
      WAVE_SINE: begin
        idx = int'((64'(ph[21:0]) * QuarterDepth) >> 22);
        v = ph[22] ? sine_quarter[QuarterDepth - idx] : sine_quarter[idx];
        return ph[23] ? -v : v;
      end
      WAVE_SAW: return 32768 - int'(ph >> 8);
      WAVE_SQUARE: return ph[23] ? 32768 : -32768;
      default: begin
        lsb = noise_q[0];
        noise_q = noise_q >> 1;
        if (lsb) begin
          noise_q = noise_q ^ NoiseTaps;
        end
        return int'(noise_q[31:16]) - 32768;
      end
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] scale_sample(input int w, input int gain);
    longint prod;
    longint res;
    longint unsigned mag;
    prod = longint'(w) * longint'(gain) * longint'(amplitude_q);
    mag = (prod < 0) ? -prod : prod;
    mag = (mag + (64'd1 << (RoundShift - 1))) >> RoundShift;
    if (prod < 0) begin
      res = (mag > SampleMax + 1) ? -SampleMax - 1 : -longint'(mag);
    end else begin
      res = (mag > SampleMax) ? SampleMax : longint'(mag);
    end
    return SampleW'(res);
  endfunction

  function automatic stereo_pair_t predict_pair(input logic [31:0] t);
    logic [63:0] product;
    int left_gain;
    int right_gain;
    int wl;
    int wr;
    stereo_pair_t pair;
    product = 64'(t) * 64'(frequency_q);
    left_gain = 32768 - ((int'(pan_q) > 0) ? int'(pan_q) : 0);
    right_gain = 32768 + ((int'(pan_q) < 0) ? int'(pan_q) : 0);
    wl = wave_value(product[23:0]);
    wr = (waveform_q == WAVE_NOISE) ? wave_value(product[23:0]) : wl;
    pair.left = scale_sample(wl, left_gain);
    pair.right = scale_sample(wr, right_gain);
    return pair;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("Mismatch: %s", msg);
    end
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    case (index)
      REG_WAVEFORM:  waveform_q = wave_t'(data[1:0]);
      REG_FREQUENCY: frequency_q = data[23:0];
      REG_AMPLITUDE: amplitude_q = data[15:0];
      REG_PAN:       pan_q = data[15:0];
      default: ;
    endcase
  endtask

  task automatic send_time(input logic [31:0] t);
    int gap;
    @(negedge clk);
    times.valid <= 1'b1;
    times.sample_time <= t;
    do @(posedge clk); while (!times.ready);
    expected_pairs.push_back(predict_pair(t));
    gap = tx_gaps ? idle_length() : 0;
    if (gap > 0) begin
      @(negedge clk);
      times.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_for_idle();
    @(negedge clk);
    times.valid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    // Reset settings leave the frequency at zero, so the phase stays at zero.
    send_time(32'h0001_0000);
    send_time(32'hFFFF_FFFF);
    wait_for_idle();
    write_reg(REG_FREQUENCY, 24'h000100);
    foreach (AllWaves[i]) begin
      wait_for_idle();
      write_reg(REG_WAVEFORM, CfgDataW'(AllWaves[i]));
      send_time(32'h0000_4000);
      send_time(32'h0000_C000);
      send_time(32'h0001_0000);
      send_time(32'hFFFF_FFFF);
    end
    // Full amplitude with the pan at either end drives the square into saturation.
    wait_for_idle();
    write_reg(REG_WAVEFORM, CfgDataW'(WAVE_SQUARE));
    write_reg(REG_AMPLITUDE, 24'h00FFFF);
    write_reg(REG_PAN, 24'h007FFF);
    send_time(32'h0000_8000);
    send_time(32'h0000_0000);
    wait_for_idle();
    write_reg(REG_PAN, 24'h008000);
    send_time(32'h0000_8000);
    wait_for_idle();
    write_reg(REG_AMPLITUDE, 24'h000000);
    send_time(32'h0000_8000);
    wait_for_idle();
    write_reg(REG_WAVEFORM, CfgDataW'(WAVE_SAW));
    write_reg(REG_FREQUENCY, 24'hFFFFFF);
    write_reg(REG_AMPLITUDE, CfgDataW'(UnityGain));
    send_time(32'hFFFF_FFFF);
    send_time(32'h0000_0001);
    // Bits above the waveform field and an unmapped index must have no effect.
    wait_for_idle();
    write_reg(REG_WAVEFORM, 24'hFFFFFC);
    write_reg(RegUnmapped, 24'hFFFFFF);
    send_time(32'h1234_5678);
    wait_for_idle();
  endtask

  task automatic test_random_settings();
    logic [CfgDataW-1:0] fill;
    logic [15:0] value;
    logic [31:0] t;
    int mode;
    int pick;
    for (int phase = 0; phase < PhaseCount; phase++) begin
      wait_for_idle();
      mode = (phase / 4) % 4;
      tx_gaps = mode[0];
      rx_stalls = mode[1];

      fill = CfgDataW'($urandom);
      write_reg(REG_WAVEFORM, {fill[CfgDataW-1:2], AllWaves[phase % 4]});

      pick = $urandom_range(0, 7);
      if (pick == 0) fill = '0;
      else if (pick == 1) fill = '1;
      else if (pick < 5) fill = CfgDataW'($urandom_range(1, 24'h03FFFF));
      else fill = CfgDataW'($urandom);
      write_reg(REG_FREQUENCY, fill);

      pick = $urandom_range(0, 7);
      if (pick == 0) value = 16'h0000;
      else if (pick == 1) value = 16'hFFFF;
      else if (pick < 5) value = 16'($urandom_range(0, 256));
      else value = 16'($urandom);
      fill = CfgDataW'($urandom);
      write_reg(REG_AMPLITUDE, {fill[CfgDataW-1:16], value});

      pick = $urandom_range(0, 7);
      if (pick == 0) value = 16'h8000;
      else if (pick == 1) value = 16'h7FFF;
      else value = 16'($urandom);
      fill = CfgDataW'($urandom);
      write_reg(REG_PAN, {fill[CfgDataW-1:16], value});

      write_reg(CfgIndexW'($urandom_range(RegUnmapped, (1 << CfgIndexW) - 1)),
                CfgDataW'($urandom));

      t = $urandom;
      for (int k = 0; k < PhaseItems; k++) begin
        // A quarter of the items step forward from the last time like a sample clock.
        t = ($urandom_range(0, 3) == 0) ? t + $urandom_range(1, 64) : $urandom;
        send_time(t);
      end
    end
    wait_for_idle();
  endtask

  task automatic test_output_backpressure();
    wait_for_idle();
    write_reg(REG_WAVEFORM, CfgDataW'(WAVE_NOISE));
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
    hold_request = 1'b1;
    for (int k = 0; k < 30; k++) begin
      send_time($urandom);
    end
    wait_for_idle();
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    samples.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
      end else if (hold_left == 0 && rx_stalls && $urandom_range(0, 3) == 0) begin
        hold_left = idle_length();
      end
      if (hold_left > 0) begin
        hold_left--;
        samples.ready <= 1'b0;
      end else begin
        samples.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && samples.valid && samples.ready) begin
      if (expected_pairs.size() == 0) begin
        note_failure($sformatf("transaction with no result pending: left %0d right %0d",
                               samples.left_sample, samples.right_sample));
      end else begin
        oldest = expected_pairs.pop_front();
        if (samples.left_sample !== oldest.left) begin
          note_failure($sformatf("left sample expected %0d, got %0d",
                                 oldest.left, samples.left_sample));
        end
        if (samples.right_sample !== oldest.right) begin
          note_failure($sformatf("right sample expected %0d, got %0d",
                                 oldest.right, samples.right_sample));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : main
    bit [63:0] u;
    bit [63:0] u2;
    bit [63:0] acc;
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    times.valid = 1'b0;
    times.sample_time = '0;

    for (int k = 0; k <= QuarterDepth; k++) begin
      u = (64'(k) << 30) / QuarterDepth;
      u2 = (u * u) >> 30;
      acc = SineCoef[5];
      for (int n = 4; n >= 0; n--) begin
        acc = SineCoef[n] - ((acc * u2) >> 30);
      end
      acc = (acc * u) >> 30;
      sine_quarter[k] = int'((acc * 64'd32768 + (64'd1 << 29)) >> 30);
    end
    waveform_q = WAVE_SINE;
    frequency_q = '0;
    amplitude_q = UnityGain;
    pan_q = '0;
    noise_q = NoiseSeed;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    test_directed_cases();
    test_random_settings();
    test_output_backpressure();

    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
